// ----- rtl/pclb_pkg.sv -----
// ----------------------------------------------------------------------------
// pclb_pkg: shared types and helpers for the periodic cell-list binner
// Holds operation and result codes, the command word passed from the front
// part to the back part, and the periodic neighbor wrap helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pclb_pkg;

   localparam int DEF_DIMENSIONS    = 2;
   localparam int DEF_MAX_SIDE      = 32;
   localparam int DEF_CELL_CAPACITY = 32;

   // fixed by the field ranges: coordinates up to 63, side up to 64
   localparam int COORD_W   = 6;
   localparam int SIDE_W    = 7;
   localparam int ID_W      = 16;
   localparam int POS_W     = 16;
   localparam int SCALE_W   = 24;
   localparam int COUNT_W   = 6;
   localparam int RESULT_LIMIT = 32;
   localparam int MIN_SIDE  = 4;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_ENTRY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic {
      REG_SIDE  = 1'b0,
      REG_SCALE = 1'b1
   } reg_index_type;

   typedef struct packed {
      op_type                    op;
      logic [ID_W-1:0]           id;
      logic [SIDE_W-1:0]         side;
      logic [2:0][COORD_W-1:0]   coord;
   } cmd_type;

   // neighbor coordinate for offset code d (0: minus one, 1: same, 2: plus one)
   function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                     input logic [1:0] d,
                                                     input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0]  smax;
      logic [COORD_W-1:0] r;
      smax = side - SIDE_W'(1);
      r = c;
      if (d == 2'd0) begin
         r = (c == '0) ? smax[COORD_W-1:0] : c - COORD_W'(1);
      end else if (d == 2'd2) begin
         r = (c == smax[COORD_W-1:0]) ? '0 : c + COORD_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pclb_ram.sv -----
// ----------------------------------------------------------------------------
// pclb_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module pclb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pclb_front.sv -----
// ----------------------------------------------------------------------------
// pclb_front: input stage of the binner
// Takes a word, maps each used coordinate to its cell index with one shared
// multiplier, and hands a command to the queue; opcode 3 words are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pclb_front #(
   parameter int DIMENSIONS = pclb_pkg::DEF_DIMENSIONS,
   parameter int MAX_SIDE   = pclb_pkg::DEF_MAX_SIDE
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           hold,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [1:0]                     req_op,
   input  wire logic [pclb_pkg::ID_W-1:0]      req_id,
   input  wire logic [2:0][pclb_pkg::POS_W-1:0] req_pos,
   input  wire logic [5:0]                     cfg_side,
   input  wire logic [pclb_pkg::SCALE_W-1:0]   cfg_scale,
   output logic                                cmd_valid,
   input  wire logic                           cmd_ready,
   output pclb_pkg::cmd_type                   cmd
);

   localparam int PROD_W = pclb_pkg::POS_W + pclb_pkg::SCALE_W;

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_MUL   = 4'b0010,
      F_CLAMP = 4'b0100,
      F_PUSH  = 4'b1000
   } fstate_type;

   fstate_type                          state_ff, state_in;
   pclb_pkg::cmd_type                   cmd_ff, cmd_in;
   logic [2:0][pclb_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [1:0]                          axis_ff, axis_in;
   logic [PROD_W-1:0]                   prod_ff, prod_in;
   logic [pclb_pkg::SIDE_W-1:0]         side_eff;
   logic [pclb_pkg::SIDE_W-1:0]         smax;
   logic [pclb_pkg::SCALE_W-1:0]        cell_raw;

   always_comb begin
      side_eff = pclb_pkg::SIDE_W'(cfg_side);
      if (side_eff < pclb_pkg::SIDE_W'(pclb_pkg::MIN_SIDE)) begin
         side_eff = pclb_pkg::SIDE_W'(pclb_pkg::MIN_SIDE);
      end
      if (side_eff > pclb_pkg::SIDE_W'(MAX_SIDE)) begin
         side_eff = pclb_pkg::SIDE_W'(MAX_SIDE);
      end
   end

   assign req_tready = (state_ff == F_IDLE) && !hold;
   assign cmd_valid  = (state_ff == F_PUSH);
   assign cmd        = cmd_ff;
   assign smax       = cmd_ff.side - pclb_pkg::SIDE_W'(1);
   assign cell_raw   = prod_ff[PROD_W-1:16];

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      pos_in   = pos_ff;
      axis_in  = axis_ff;
      prod_in  = prod_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in.op    = pclb_pkg::op_type'(req_op);
               cmd_in.id    = req_id;
               cmd_in.side  = side_eff;
               cmd_in.coord = '0;
               pos_in       = req_pos;
               axis_in      = 2'd0;
               case (pclb_pkg::op_type'(req_op))
                  pclb_pkg::OP_CLEAR:  state_in = F_PUSH;
                  pclb_pkg::OP_INSERT,
                  pclb_pkg::OP_QUERY:  state_in = F_MUL;
                  default:             state_in = F_IDLE;
               endcase
            end
         end
         F_MUL: begin
            prod_in  = PROD_W'(pos_ff[axis_ff]) * PROD_W'(cfg_scale);
            state_in = F_CLAMP;
         end
         F_CLAMP: begin
            if (cell_raw > pclb_pkg::SCALE_W'(smax)) begin
               cmd_in.coord[axis_ff] = smax[pclb_pkg::COORD_W-1:0];
            end else begin
               cmd_in.coord[axis_ff] = cell_raw[pclb_pkg::COORD_W-1:0];
            end
            if (axis_ff == 2'(DIMENSIONS - 1)) begin
               state_in = F_PUSH;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = F_MUL;
            end
         end
         F_PUSH: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      pos_ff  <= pos_in;
      axis_ff <= axis_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- rtl/pclb_queue.sv -----
// ----------------------------------------------------------------------------
// pclb_queue: two-entry command queue
// Decouples the front part from the back part so each may stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module pclb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pclb_pkg::cmd_type in_cmd,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pclb_pkg::cmd_type      out_cmd
);

   pclb_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pclb_back.sv -----
// ----------------------------------------------------------------------------
// pclb_back: cell store sequencer
// Runs clear sweeps, neighbor inserts and queries against the occupancy
// and member memories and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pclb_back #(
   parameter int DIMENSIONS    = pclb_pkg::DEF_DIMENSIONS,
   parameter int MAX_SIDE      = pclb_pkg::DEF_MAX_SIDE,
   parameter int CELL_CAPACITY = pclb_pkg::DEF_CELL_CAPACITY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   output logic                               init_busy,
   input  wire logic                          cmd_valid,
   output logic                               cmd_ready,
   input  wire pclb_pkg::cmd_type             cmd,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output pclb_pkg::kind_type                 rsp_kind,
   output logic [pclb_pkg::ID_W-1:0]          rsp_id,
   output logic [pclb_pkg::COUNT_W-1:0]       rsp_count,
   output logic                               rsp_overflow,
   output logic                               rsp_entry,
   output logic                               rsp_last
);

   localparam int CELLS   = (DIMENSIONS == 3) ? MAX_SIDE * MAX_SIDE * MAX_SIDE
                                              : MAX_SIDE * MAX_SIDE;
   localparam int SAW     = $clog2(CELLS);
   localparam int SLOT_W  = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int OCC_W   = $clog2(CELL_CAPACITY + 1);
   localparam int MAW     = SAW + SLOT_W;
   localparam int PW      = SAW + pclb_pkg::SIDE_W;
   localparam int NLIM    = (CELL_CAPACITY < pclb_pkg::RESULT_LIMIT)
                            ? CELL_CAPACITY : pclb_pkg::RESULT_LIMIT;
   localparam int N_W     = $clog2(pclb_pkg::RESULT_LIMIT + 1);

   typedef enum logic [10:0] {
      B_INIT  = 11'b00000000001,
      B_IDLE  = 11'b00000000010,
      B_SWEEP = 11'b00000000100,
      B_ADDR  = 11'b00000001000,
      B_ADDR2 = 11'b00000010000,
      B_RD    = 11'b00000100000,
      B_WR    = 11'b00001000000,
      B_QCHK  = 11'b00010000000,
      B_QMEM  = 11'b00100000000,
      B_QOUT  = 11'b01000000000,
      B_DONE  = 11'b10000000000
   } bstate_type;

   bstate_type                       state_ff, state_in;
   pclb_pkg::cmd_type                cmd_ff, cmd_in;
   logic [1:0]                       di_ff, di_in, dj_ff, dj_in, dk_ff, dk_in;
   logic [SAW-1:0]                   ser_ff, ser_in;
   logic [pclb_pkg::COORD_W-1:0]     zc_ff, zc_in;
   logic [SAW-1:0]                   sweep_ff, sweep_in;
   logic                             ovf_ff, ovf_in;
   logic [OCC_W-1:0]                 home_ff, home_in;
   logic [OCC_W-1:0]                 qocc_ff, qocc_in;
   logic [N_W-1:0]                   n_ff, n_in, k_ff, k_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   pclb_pkg::kind_type               kind_ff, kind_in;
   logic [pclb_pkg::ID_W-1:0]        id_ff, id_in;
   logic [pclb_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                             ovfo_ff, ovfo_in;
   logic                             entry_ff, entry_in;
   logic                             last_ff, last_in;

   logic                             occ_we, occ_re;
   logic [SAW-1:0]                   occ_waddr;
   logic [OCC_W-1:0]                 occ_wdata, occ_rdata;
   logic                             mem_we, mem_re;
   logic [MAW-1:0]                   mem_waddr, mem_raddr;
   logic [pclb_pkg::ID_W-1:0]        mem_rdata;

   logic                             out_free;
   logic [pclb_pkg::COORD_W-1:0]     nx, ny, nz;
   logic [PW-1:0]                    t2, t3;
   logic                             zlast, nb_done, is_home;
   logic [OCC_W-1:0]                 occ_next;
   logic [N_W-1:0]                   n_calc;

   function automatic logic [pclb_pkg::COUNT_W-1:0] sat_count(input logic [OCC_W-1:0] v);
      logic [7:0] w;
      w = 8'(v);
      return (w > 8'd63) ? 6'd63 : w[5:0];
   endfunction

   pclb_ram #(.WIDTH(OCC_W), .DEPTH(CELLS)) u_occ (
      .clock   (clock),
      .wr_en   (occ_we),
      .wr_addr (occ_waddr),
      .wr_data (occ_wdata),
      .rd_en   (occ_re),
      .rd_addr (ser_ff),
      .rd_data (occ_rdata)
   );

   pclb_ram #(.WIDTH(pclb_pkg::ID_W), .DEPTH(CELLS << SLOT_W)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (cmd_ff.id),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign init_busy  = (state_ff == B_INIT);
   assign cmd_ready  = (state_ff == B_IDLE);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_id       = id_ff;
   assign rsp_count    = count_ff;
   assign rsp_overflow = ovfo_ff;
   assign rsp_entry    = entry_ff;
   assign rsp_last     = last_ff;

   assign nx      = pclb_pkg::wrap_coord(cmd_ff.coord[0], di_ff, cmd_ff.side);
   assign ny      = pclb_pkg::wrap_coord(cmd_ff.coord[1], dj_ff, cmd_ff.side);
   assign nz      = pclb_pkg::wrap_coord(cmd_ff.coord[2], dk_ff, cmd_ff.side);
   assign t2      = PW'(nx) * PW'(cmd_ff.side) + PW'(ny);
   assign t3      = PW'(ser_ff) * PW'(cmd_ff.side) + PW'(zc_ff);
   assign zlast   = (DIMENSIONS != 3) || (dk_ff == 2'd2);
   assign nb_done = (di_ff == 2'd2) && (dj_ff == 2'd2) && zlast;
   assign is_home = (di_ff == 2'd1) && (dj_ff == 2'd1) &&
                    ((DIMENSIONS != 3) || (dk_ff == 2'd1));
   assign occ_next = occ_rdata + OCC_W'(1);

   always_comb begin
      n_calc = N_W'(occ_rdata);
      if (8'(occ_rdata) > 8'(NLIM)) begin
         n_calc = N_W'(NLIM);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      di_in        = di_ff;
      dj_in        = dj_ff;
      dk_in        = dk_ff;
      ser_in       = ser_ff;
      zc_in        = zc_ff;
      sweep_in     = sweep_ff;
      ovf_in       = ovf_ff;
      home_in      = home_ff;
      qocc_in      = qocc_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      id_in        = id_ff;
      count_in     = count_ff;
      ovfo_in      = ovfo_ff;
      entry_in     = entry_ff;
      last_in      = last_ff;
      occ_we       = 1'b0;
      occ_re       = 1'b0;
      occ_waddr    = ser_ff;
      occ_wdata    = '0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = {ser_ff, occ_rdata[SLOT_W-1:0]};
      mem_raddr    = {ser_ff, k_ff[SLOT_W-1:0]};

      case (state_ff)
         B_INIT, B_SWEEP: begin
            occ_we    = 1'b1;
            occ_waddr = sweep_ff;
            sweep_in  = sweep_ff + SAW'(1);
            if (sweep_ff == SAW'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = (state_ff == B_INIT) ? B_IDLE : B_DONE;
            end
         end
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               ovf_in = 1'b0;
               di_in  = 2'd1;
               dj_in  = 2'd1;
               dk_in  = 2'd1;
               case (cmd.op)
                  pclb_pkg::OP_CLEAR: state_in = B_SWEEP;
                  pclb_pkg::OP_INSERT: begin
                     di_in    = 2'd0;
                     dj_in    = 2'd0;
                     dk_in    = (DIMENSIONS == 3) ? 2'd0 : 2'd1;
                     state_in = B_ADDR;
                  end
                  pclb_pkg::OP_QUERY: state_in = B_ADDR;
                  default:            state_in = B_IDLE;
               endcase
            end
         end
         B_ADDR: begin
            ser_in   = SAW'(t2);
            zc_in    = nz;
            state_in = (DIMENSIONS == 3) ? B_ADDR2 : B_RD;
         end
         B_ADDR2: begin
            ser_in   = SAW'(t3);
            state_in = B_RD;
         end
         B_RD: begin
            occ_re   = 1'b1;
            state_in = (cmd_ff.op == pclb_pkg::OP_QUERY) ? B_QCHK : B_WR;
         end
         B_WR: begin
            if (occ_rdata < OCC_W'(CELL_CAPACITY)) begin
               occ_we    = 1'b1;
               occ_wdata = occ_next;
               mem_we    = 1'b1;
               if (is_home) begin
                  home_in = occ_next;
               end
            end else begin
               ovf_in = 1'b1;
               if (is_home) begin
                  home_in = occ_rdata;
               end
            end
            // step through the neighbors, innermost axis first
            if (nb_done) begin
               state_in = B_DONE;
            end else begin
               state_in = B_ADDR;
               if (!zlast) begin
                  dk_in = dk_ff + 2'd1;
               end else begin
                  dk_in = (DIMENSIONS == 3) ? 2'd0 : 2'd1;
                  if (dj_ff != 2'd2) begin
                     dj_in = dj_ff + 2'd1;
                  end else begin
                     dj_in = 2'd0;
                     di_in = di_ff + 2'd1;
                  end
               end
            end
         end
         B_QCHK: begin
            qocc_in = occ_rdata;
            n_in    = n_calc;
            k_in    = '0;
            state_in = (n_calc == '0) ? B_DONE : B_QMEM;
         end
         B_QMEM: begin
            mem_re   = 1'b1;
            state_in = B_QOUT;
         end
         B_QOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = pclb_pkg::KIND_ENTRY;
               id_in        = mem_rdata;
               count_in     = sat_count(qocc_ff);
               ovfo_in      = 1'b0;
               entry_in     = 1'b1;
               last_in      = (k_ff == n_ff - N_W'(1));
               k_in         = k_ff + N_W'(1);
               state_in     = (k_ff == n_ff - N_W'(1)) ? B_IDLE : B_QMEM;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               id_in        = '0;
               count_in     = '0;
               ovfo_in      = 1'b0;
               entry_in     = 1'b0;
               last_in      = 1'b1;
               case (cmd_ff.op)
                  pclb_pkg::OP_INSERT: begin
                     kind_in  = pclb_pkg::KIND_ACK;
                     count_in = sat_count(home_ff);
                     ovfo_in  = ovf_ff;
                  end
                  pclb_pkg::OP_QUERY: kind_in = pclb_pkg::KIND_ENTRY;
                  default:            kind_in = pclb_pkg::KIND_CLEAR;
               endcase
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      di_ff    <= di_in;
      dj_ff    <= dj_in;
      dk_ff    <= dk_in;
      ser_ff   <= ser_in;
      zc_ff    <= zc_in;
      ovf_ff   <= ovf_in;
      home_ff  <= home_in;
      qocc_ff  <= qocc_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      kind_ff  <= kind_in;
      id_ff    <= id_in;
      count_ff <= count_in;
      ovfo_ff  <= ovfo_in;
      entry_ff <= entry_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

// ----- rtl/periodic_cell_list_binner.sv -----
// ----------------------------------------------------------------------------
// periodic_cell_list_binner: cell-list binner for a periodic box
// Bins agent ids into a grid of cells and their periodic neighbors and
// streams a cell's stored ids on query.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: opcode; tdata: id, x, y, z
//   rsp      out  rsp_tvalid/tready    tuser: kind; tdata: id, count, flags; tlast
//   csr      in   csr_valid/ready      csr_index, csr_data
//
// Front part: one shared 16x24 multiplier; it takes no new word until its
// command is handed to the queue. Insert: for each neighbor cell an address
// step (two in 3D), a read and a write on the occupancy memory port, then
// the acknowledge. Query: address, read and check steps, then a member read
// and output per stored id. Clear: one occupancy entry a cycle, over all
// MAX_SIDE^DIMENSIONS entries. After reset the same sweep runs before any
// word is taken. A stalled result holds in the output register; the
// two-entry queue lets the front take words meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_cell_list_binner #(
   parameter int DIMENSIONS    = pclb_pkg::DEF_DIMENSIONS,
   parameter int MAX_SIDE      = pclb_pkg::DEF_MAX_SIDE,
   parameter int CELL_CAPACITY = pclb_pkg::DEF_CELL_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // agent_id, pos_x, pos_y, pos_z
   input  wire logic [1:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // neighbor_id, neighbor_count, overflow, entry_valid
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_data
);

   logic [5:0]                           side_ff;
   logic [pclb_pkg::SCALE_W-1:0]         scale_ff;
   logic                                 init_busy;
   logic                                 fq_valid, fq_ready, qb_valid, qb_ready;
   pclb_pkg::cmd_type                    fq_cmd, qb_cmd;
   logic [2:0][pclb_pkg::POS_W-1:0]      pos;
   pclb_pkg::kind_type                   kind;
   logic [pclb_pkg::ID_W-1:0]            nid;
   logic [pclb_pkg::COUNT_W-1:0]         ncount;
   logic                                 novf, nvalid;

   assign csr_ready = 1'b1;
   assign pos[0] = req_tdata[31:16];
   assign pos[1] = req_tdata[47:32];
   assign pos[2] = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= 6'd16;
         scale_ff <= 24'd4096;
      end else if (csr_valid && csr_ready) begin
         case (pclb_pkg::reg_index_type'(csr_index))
            pclb_pkg::REG_SIDE:  side_ff  <= csr_data[5:0];
            pclb_pkg::REG_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pclb_front #(.DIMENSIONS(DIMENSIONS), .MAX_SIDE(MAX_SIDE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (init_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_id     (req_tdata[15:0]),
      .req_pos    (pos),
      .cfg_side   (side_ff),
      .cfg_scale  (scale_ff),
      .cmd_valid  (fq_valid),
      .cmd_ready  (fq_ready),
      .cmd        (fq_cmd)
   );

   pclb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_cmd   (qb_cmd)
   );

   pclb_back #(
      .DIMENSIONS    (DIMENSIONS),
      .MAX_SIDE      (MAX_SIDE),
      .CELL_CAPACITY (CELL_CAPACITY)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .init_busy    (init_busy),
      .cmd_valid    (qb_valid),
      .cmd_ready    (qb_ready),
      .cmd          (qb_cmd),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind     (kind),
      .rsp_id       (nid),
      .rsp_count    (ncount),
      .rsp_overflow (novf),
      .rsp_entry    (nvalid),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tuser = kind;
   assign rsp_tdata = {nvalid, novf, ncount, nid};

endmodule

`default_nettype wire

// ----- tb/periodic_cell_list_binner_tb.sv -----
// ----------------------------------------------------------------------------
// periodic_cell_list_binner_tb: self-checking bench for the cell-list binner
// Drives clear, insert and query words over several grid settings, predicts
// every result word from its own copy of the cell store and compares each
// accepted result field by field, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class binner_scoreboard;
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] id;
      logic [5:0]  count;
      logic        ovf;
      logic        valid;
      logic        last;
   } rsp_word_type;

   logic [5:0]   side_reg;
   logic [23:0]  scale_reg;
   logic [5:0]   occ [1024];
   logic [15:0]  members [32768];
   rsp_word_type pending [$];
   int           errors;
   int           checked;

   function new();
      side_reg = 16;
      scale_reg = 4096;
      foreach (occ[i]) occ[i] = 0;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(bit idx, logic [23:0] value);
      if (idx == pclb_pkg::REG_SIDE) side_reg = value[5:0];
      else scale_reg = value;
   endfunction

   function int grid_side();
      int s;
      s = side_reg;
      if (s < 4) s = 4;
      if (s > 32) s = 32;
      return s;
   endfunction

   function int to_cell(logic [15:0] pos, int s);
      longint c;
      c = (longint'(pos) * longint'(scale_reg)) >> 16;
      if (c > s - 1) c = s - 1;
      return int'(c);
   endfunction

   function void push(logic [1:0] k, logic [15:0] id, int cnt, bit o, bit v, bit l);
      rsp_word_type w;
      w.kind = k; w.id = id; w.count = (cnt > 63) ? 6'd63 : cnt[5:0];
      w.ovf = o; w.valid = v; w.last = l;
      pending.push_back(w);
   endfunction

   function void note_request(logic [1:0] op, logic [15:0] id, logic [15:0] px,
                              logic [15:0] py);
      int s, cx, cy, cidx, n, x, y;
      bit ovf;
      s = grid_side();
      cx = to_cell(px, s);
      cy = to_cell(py, s);
      case (op)
         pclb_pkg::OP_CLEAR: begin
            foreach (occ[i]) occ[i] = 0;
            push(pclb_pkg::KIND_CLEAR, 0, 0, 0, 0, 1);
         end
         pclb_pkg::OP_INSERT: begin
            ovf = 0;
            for (int di = 0; di < 3; di++)
               for (int dj = 0; dj < 3; dj++) begin
                  x = (cx + s - 1 + di) % s;
                  y = (cy + s - 1 + dj) % s;
                  cidx = x * s + y;
                  if (occ[cidx] < 32) begin
                     members[cidx * 32 + occ[cidx]] = id;
                     occ[cidx] = occ[cidx] + 6'd1;
                  end else ovf = 1;
               end
            push(pclb_pkg::KIND_ACK, 0, occ[cx * s + cy], ovf, 0, 1);
         end
         pclb_pkg::OP_QUERY: begin
            cidx = cx * s + cy;
            n = occ[cidx];
            if (n > 32) n = 32;
            if (n == 0) push(pclb_pkg::KIND_ENTRY, 0, 0, 0, 0, 1);
            for (int k = 0; k < n; k++)
               push(pclb_pkg::KIND_ENTRY, members[cidx * 32 + k], occ[cidx], 0, 1,
                    k + 1 == n);
         end
         default: ;
      endcase
   endfunction

   function void check_result(logic [1:0] k, logic [23:0] d, logic l);
      rsp_word_type w;
      if (pending.size() == 0) begin
         $error("unexpected result word kind=%0d data=%h", k, d);
         errors++;
         return;
      end
      w = pending.pop_front();
      checked++;
      if (k !== w.kind) begin
         $error("kind exp %0d got %0d", w.kind, k); errors++;
      end
      if (d[15:0] !== w.id) begin
         $error("neighbor_id exp %0d got %0d", w.id, d[15:0]); errors++;
      end
      if (d[21:16] !== w.count) begin
         $error("neighbor_count exp %0d got %0d", w.count, d[21:16]); errors++;
      end
      if (d[22] !== w.ovf) begin
         $error("overflow exp %0d got %0d", w.ovf, d[22]); errors++;
      end
      if (d[23] !== w.valid) begin
         $error("entry_valid exp %0d got %0d", w.valid, d[23]); errors++;
      end
      if (l !== w.last) begin
         $error("last exp %0d got %0d", w.last, l); errors++;
      end
   endfunction
endclass

module periodic_cell_list_binner_tb;

   localparam int CYCLE_LIMIT = 900000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [23:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int words_sent = 0;
   binner_scoreboard sb;

   periodic_cell_list_binner uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver side: random stall, check on each accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // valid stays up between back-to-back words; it drops only while idling or in drain
   task automatic send_word(logic [1:0] op, logic [15:0] id, logic [15:0] px,
                            logic [15:0] py, logic [15:0] pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {pz, py, px, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, id, px, py);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_csr(bit idx, logic [23:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int n, int idle, int stall);
      logic [1:0] op;
      int r;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 3) op = pclb_pkg::OP_CLEAR;
         else if (r < 55) op = pclb_pkg::OP_INSERT;
         else if (r < 97) op = pclb_pkg::OP_QUERY;
         else op = pclb_pkg::OP_NONE;
         // mostly clustered positions so cells fill up
         if ($urandom_range(3) != 0)
            send_word(op, 16'($urandom), 16'($urandom_range(16'h3FFF)),
                      16'($urandom_range(16'h3FFF)), 16'($urandom));
         else
            send_word(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      send_idle_pct = 0;
      drain();
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, wrap at edges, empty and long queries, full cells
      send_word(pclb_pkg::OP_QUERY, 0, 0, 0, 0);
      send_word(pclb_pkg::OP_INSERT, 16'hFFFF, 0, 0, 16'hFFFF);
      send_word(pclb_pkg::OP_INSERT, 16'h0001, 16'hFFFF, 16'hFFFF, 0);
      send_word(pclb_pkg::OP_QUERY, 0, 16'hFFFF, 0, 0);
      send_word(pclb_pkg::OP_NONE, 16'h1234, 5, 5, 5);
      for (int i = 0; i < 34; i++)
         send_word(pclb_pkg::OP_INSERT, 16'(i), 16'h1000, 16'h1000, 0);
      send_word(pclb_pkg::OP_QUERY, 0, 16'h1000, 16'h1000, 0);
      send_word(pclb_pkg::OP_QUERY, 0, 16'h2000, 16'h0800, 0);
      drain();
      write_csr(pclb_pkg::REG_SIDE, 24'd8);
      send_word(pclb_pkg::OP_QUERY, 0, 16'h1000, 16'h1000, 0);
      send_word(pclb_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(pclb_pkg::OP_QUERY, 0, 16'h1000, 16'h1000, 0);
      drain();
      random_phase(80, 0, 0);
      write_csr(pclb_pkg::REG_SIDE, 24'd2);
      write_csr(pclb_pkg::REG_SCALE, 24'd1024);
      random_phase(80, 47, 0);
      write_csr(pclb_pkg::REG_SIDE, 24'd63);
      write_csr(pclb_pkg::REG_SCALE, 24'hFFFFFF);
      random_phase(80, 0, 47);
      write_csr(pclb_pkg::REG_SIDE, 24'd32);
      write_csr(pclb_pkg::REG_SCALE, 24'd0);
      random_phase(20, 26, 26);
      write_csr(pclb_pkg::REG_SCALE, 24'd2048);
      random_phase(56, 26, 26);
      $display("sent %0d request words, checked %0d result words", words_sent, sb.checked);
      $display("covered side 2..63, scale 0..max, wrap, overflow and long queries");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
